// File: rtl/core/candela_table_bilinear_sampler_defines.svh
// ----------------------------------------------------------------------------
// Candela sampler assertion macros
// Shared concurrent assertion wrappers for the candela table sampler.
// ----------------------------------------------------------------------------
`ifndef CANDELA_TABLE_BILINEAR_SAMPLER_DEFINES_SVH
`define CANDELA_TABLE_BILINEAR_SAMPLER_DEFINES_SVH

// Assertion on an explicit clock and active-low reset.
`define CTS_ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assertion on the block clock and reset.
`define CTS_ASSERT(lbl, prop, msg) `CTS_ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/core/cts_pkg.sv
// ----------------------------------------------------------------------------
// Candela sampler package
// Opcodes, register indexes, transaction payload types and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cts_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_H = 2'd0,
    OP_LOAD_V = 2'd1,
    OP_LOAD_C = 2'd2,
    OP_SAMPLE = 2'd3
  } cts_op_e;

  localparam logic [1:0] CFG_HCOUNT = 2'd0;
  localparam logic [1:0] CFG_VCOUNT = 2'd1;

  typedef struct packed {
    cts_op_e     opcode;
    logic [12:0] entry_index;
    logic [23:0] load_value;
    logic [15:0] query_horizontal;
    logic [15:0] query_vertical;
  } cts_req_t;

  typedef struct packed {
    logic [23:0] intensity;
    logic [5:0]  horizontal_slot;
    logic [6:0]  vertical_slot;
  } cts_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LO_RD,
    S_LO_CHK,
    S_HI_CHK,
    S_BS_RD,
    S_BS_CHK,
    S_A0,
    S_A1,
    S_DIV,
    S_G00,
    S_G10,
    S_G01,
    S_G11,
    S_V1,
    S_V1B,
    S_Y1,
    S_Y2,
    S_OUT
  } cts_state_e;

endpackage

// File: rtl/core/cts_stream_if.sv
// ----------------------------------------------------------------------------
// Candela sampler stream interface
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cts_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/cts_div.sv
// ----------------------------------------------------------------------------
// Candela sampler fraction divider
// Restoring divider, one quotient bit per cycle, for a dividend below the
// divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cts_div import cts_pkg::*; #(
  parameter int FB = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [15:0]   num_i,
  input  logic [15:0]   den_i,
  output logic          done_o,
  output logic [FB-1:0] quo_o
);
  localparam int CW = $clog2(FB + 1);

  logic [16:0]   rem_q, r2;
  logic [15:0]   den_q;
  logic [FB-1:0] quo_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q, take;

  assign r2   = {rem_q[15:0], 1'b0};
  assign take = r2 >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(FB);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= take ? (r2 - {1'b0, den_q}) : r2;
      quo_q <= {quo_q[FB-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// File: rtl/core/cts_mul.sv
// ----------------------------------------------------------------------------
// Candela sampler multiplier
// Shared weight-by-value multiplier with a registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cts_mul import cts_pkg::*; #(
  parameter int AW = 13,
  parameter int BW = 36
) (
  input  logic             clk_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);
  logic [AW+BW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (AW + BW)'(a_i) * (AW + BW)'(b_i);
  end

  assign p_o = p_q;
endmodule

// File: rtl/core/candela_table_bilinear_sampler.sv
// ----------------------------------------------------------------------------
// Candela table bilinear sampler
// Loads angle and candela tables and answers bilinear samples over them.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Payload    Notes
// req_i     in   cts_req_t  loads write a table, a sample runs the sequencer
// rsp_o     out  cts_rsp_t  one transaction per sample, held in an output reg
// cfg_*     in   2 regs     horizontal and vertical counts, write only
//
// A load transaction writes its table entry, if in range, when accepted. The
// time a sample takes is set by the two binary searches through the
// single-read angle memories and the one-bit-per-cycle fraction divider;
// the grid blend uses one shared multiplier six times.
// The next transaction is accepted while a result waits on rsp_o; a new result
// waits in the last state until the output register is free.
// Reset sets both counts to one; the tables are undefined until written.
`timescale 1ns / 1ps
`include "candela_table_bilinear_sampler_defines.svh"

module candela_table_bilinear_sampler import cts_pkg::*; #(
  parameter int MAX_HORIZONTAL = 64,
  parameter int MAX_VERTICAL   = 128,
  parameter int FRACTION_BITS  = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cts_stream_if.sink   req_i,
  cts_stream_if.source rsp_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i
);
  localparam int HW = $clog2(MAX_HORIZONTAL);
  localparam int VW = $clog2(MAX_VERTICAL);
  localparam int IW = (HW > VW) ? HW : VW;
  localparam int GD = MAX_HORIZONTAL * MAX_VERTICAL;
  localparam int GW = $clog2(GD);
  localparam int FB = FRACTION_BITS;
  localparam int AW = FB + 1;
  localparam int VB = 24 + FB;
  localparam int PB = AW + VB;
  localparam logic [AW-1:0] ONE = AW'(1) << FB;
  localparam logic [FB-1:0] FMAX = '1;

  // Angle and candela memories.
  logic [15:0] h_mem [MAX_HORIZONTAL];
  logic [15:0] v_mem [MAX_VERTICAL];
  logic [23:0] g_mem [GD];

  cts_state_e state_q, state_d;
  logic          axis_q, axis_d;
  logic [15:0]   qh_q, qv_q, a0_q, a0_d;
  logic [IW-1:0] lasth_q, lastv_q, lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [IW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic [FB-1:0] fx_q, fx_d, fy_q, fy_d;
  logic [PB-1:0] acc_q, acc_d;
  logic [VB-1:0] v0_q, v0_d, v1_q, v1_d;
  logic [6:0]    hcnt_q;
  logic [7:0]    vcnt_q;
  logic          out_valid_q, out_load;
  cts_rsp_t      out_data_q;

  logic [15:0]   h_rd_q, v_rd_q, rd, q;
  logic [23:0]   g_rd_q;
  logic [IW-1:0] ang_addr, last, mid, x1, y1, gx, gy;
  logic [GW-1:0] g_addr;
  logic [IW-1:0] lasth, lastv;

  logic          fin;
  logic [IW-1:0] fin_slot;
  logic [FB-1:0] fin_frac;

  logic          div_start, div_done;
  logic [15:0]   div_num, div_den;
  logic [FB-1:0] div_quo;

  logic [AW-1:0] mul_a;
  logic [VB-1:0] mul_b;
  logic [PB-1:0] mul_p;

  logic accept;

  // Effective counts: zero acts as one, anything past the depth as the depth.
  always_comb begin
    int unsigned hc, vc;
    hc = 32'(hcnt_q);
    vc = 32'(vcnt_q);
    if (hc == 0) hc = 1;
    if (hc > MAX_HORIZONTAL) hc = MAX_HORIZONTAL;
    if (vc == 0) vc = 1;
    if (vc > MAX_VERTICAL) vc = MAX_VERTICAL;
    lasth = IW'(hc - 1);
    lastv = IW'(vc - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q <= 7'd1;
      vcnt_q <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HCOUNT: hcnt_q <= cfg_data_i[6:0];
        CFG_VCOUNT: vcnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;

  // Memory writes on load transactions, registered reads for the sequencer.
  always_ff @(posedge clk_i) begin
    logic [15:0] ang;
    ang = (req_i.data.load_value > 24'hFFFF) ? 16'hFFFF : req_i.data.load_value[15:0];
    if (accept) begin
      case (req_i.data.opcode)
        OP_LOAD_H: if (32'(req_i.data.entry_index) < MAX_HORIZONTAL)
                     h_mem[HW'(req_i.data.entry_index)] <= ang;
        OP_LOAD_V: if (32'(req_i.data.entry_index) < MAX_VERTICAL)
                     v_mem[VW'(req_i.data.entry_index)] <= ang;
        OP_LOAD_C: if (32'(req_i.data.entry_index) < GD)
                     g_mem[GW'(req_i.data.entry_index)] <= req_i.data.load_value;
        default: ;
      endcase
    end
    h_rd_q <= h_mem[ang_addr[HW-1:0]];
    v_rd_q <= v_mem[ang_addr[VW-1:0]];
    g_rd_q <= g_mem[g_addr];
  end

  assign q    = axis_q ? qv_q : qh_q;
  assign last = axis_q ? lastv_q : lasth_q;
  assign rd   = axis_q ? v_rd_q : h_rd_q;
  assign mid  = IW'(({1'b0, lo_q} + {1'b0, hi_q} + (IW + 1)'(1)) >> 1);
  assign x1   = (sx_q == lasth_q) ? '0 : sx_q + IW'(1);
  assign y1   = (sy_q == lastv_q) ? '0 : sy_q + IW'(1);

  // Grid address: vertical + vertical_count * horizontal.
  always_comb begin
    case (state_q)
      S_G10:   begin gx = x1;   gy = sy_q; end
      S_G01:   begin gx = sx_q; gy = y1;   end
      S_G11:   begin gx = x1;   gy = y1;   end
      default: begin gx = sx_q; gy = sy_q; end
    endcase
    g_addr = GW'(32'(gy) + (32'(lastv_q) + 1) * 32'(gx));
  end

  // Sequencer: a search and fraction divide per axis, then the grid blend.
  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    a0_d      = a0_q;
    sx_d      = sx_q;
    sy_d      = sy_q;
    fx_d      = fx_q;
    fy_d      = fy_q;
    acc_d     = acc_q;
    v0_d      = v0_q;
    v1_d      = v1_q;
    ang_addr  = '0;
    fin       = 1'b0;
    fin_slot  = lo_q;
    fin_frac  = '0;
    div_start = 1'b0;
    div_num   = q - a0_q;
    div_den   = rd - a0_q;
    mul_a     = '0;
    mul_b     = '0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept && req_i.data.opcode == OP_SAMPLE) begin
          axis_d  = 1'b0;
          state_d = S_LO_RD;
        end
      end
      S_LO_RD: begin
        state_d = S_LO_CHK;
      end
      S_LO_CHK: begin
        if (q < rd) begin
          fin      = 1'b1;
          fin_slot = '0;
        end else begin
          ang_addr = last;
          state_d  = S_HI_CHK;
        end
      end
      S_HI_CHK: begin
        if (q > rd) begin
          fin      = 1'b1;
          fin_slot = last;
        end else begin
          lo_d    = '0;
          hi_d    = last;
          state_d = S_BS_RD;
        end
      end
      S_BS_RD: begin
        if (lo_q < hi_q) begin
          ang_addr = mid;
          mid_d    = mid;
          state_d  = S_BS_CHK;
        end else if (lo_q < last) begin
          ang_addr = lo_q;
          state_d  = S_A0;
        end else begin
          fin = 1'b1;
        end
      end
      S_BS_CHK: begin
        if (q >= rd) lo_d = mid_q;
        else         hi_d = mid_q - IW'(1);
        state_d = S_BS_RD;
      end
      S_A0: begin
        a0_d     = rd;
        ang_addr = lo_q + IW'(1);
        state_d  = S_A1;
      end
      S_A1: begin
        if (rd > a0_q && q >= a0_q) begin
          if (q >= rd) begin
            // The fraction would reach one: saturate.
            fin      = 1'b1;
            fin_frac = FMAX;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end else begin
          fin = 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          fin      = 1'b1;
          fin_frac = div_quo;
        end
      end
      S_G00: state_d = S_G10;
      S_G10: begin
        mul_a   = ONE - AW'(fx_q);
        mul_b   = VB'(g_rd_q);
        state_d = S_G01;
      end
      S_G01: begin
        acc_d   = mul_p;
        mul_a   = AW'(fx_q);
        mul_b   = VB'(g_rd_q);
        state_d = S_G11;
      end
      S_G11: begin
        v0_d    = VB'(acc_q + mul_p);
        mul_a   = ONE - AW'(fx_q);
        mul_b   = VB'(g_rd_q);
        state_d = S_V1;
      end
      S_V1: begin
        acc_d   = mul_p;
        mul_a   = AW'(fx_q);
        mul_b   = VB'(g_rd_q);
        state_d = S_V1B;
      end
      S_V1B: begin
        v1_d    = VB'(acc_q + mul_p);
        mul_a   = ONE - AW'(fy_q);
        mul_b   = v0_q;
        state_d = S_Y1;
      end
      S_Y1: begin
        acc_d   = mul_p;
        mul_a   = AW'(fy_q);
        mul_b   = v1_q;
        state_d = S_Y2;
      end
      S_Y2: begin
        acc_d   = acc_q + mul_p;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (fin) begin
      if (!axis_q) begin
        sx_d    = fin_slot;
        fx_d    = fin_frac;
        axis_d  = 1'b1;
        state_d = S_LO_RD;
      end else begin
        sy_d    = fin_slot;
        fy_d    = fin_frac;
        state_d = S_G00;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      if (out_load)          out_valid_q <= 1'b1;
      else if (rsp_o.ready)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_i.data.opcode == OP_SAMPLE) begin
      qh_q    <= req_i.data.query_horizontal;
      qv_q    <= req_i.data.query_vertical;
      lasth_q <= lasth;
      lastv_q <= lastv;
    end
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    a0_q  <= a0_d;
    sx_q  <= sx_d;
    sy_q  <= sy_d;
    fx_q  <= fx_d;
    fy_q  <= fy_d;
    acc_q <= acc_d;
    v0_q  <= v0_d;
    v1_q  <= v1_d;
    if (out_load) begin
      out_data_q.intensity       <= 24'(acc_q >> (2 * FB));
      out_data_q.horizontal_slot <= 6'(sx_q);
      out_data_q.vertical_slot   <= 7'(sy_q);
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_data_q;

  cts_div #(.FB(FB)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  cts_mul #(.AW(AW), .BW(VB)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  `CTS_ASSERT(a_sample_starts, (accept && req_i.data.opcode == OP_SAMPLE) |=> (state_q == S_LO_RD), "sample did not start the search")
  `CTS_ASSERT(a_div_operands, div_start |-> (div_den != 16'd0 && div_num < div_den), "divider started with bad operands")
  `CTS_ASSERT(a_search_bounds, (state_q == S_BS_RD) |-> (lo_q <= hi_q && hi_q <= last), "search window out of order")
  `CTS_ASSERT(a_out_held, (out_valid_q && !rsp_o.ready) |=> (out_valid_q && $stable(out_data_q)), "pending result overwritten")
endmodule
